[hdl/sha1_message_digest_assert.svh]
// Assertion macros used by the checker of the SHA-1 digest block.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hdl/sha_pkg.sv]
// Types and constants of the SHA-1 digest block.
package sha_pkg;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [2:0] LAST_INDEX = 3'd4;
    // Word index value that marks the compression of the final block of a message.
    localparam logic [2:0] IDX_DIGEST = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } state_t;

    // Control from the sequencer to the round engine.
    typedef struct packed {
        logic       start;
        logic       load_en;
        logic       round_en;
        logic       fold;
        logic       init;
        logic [6:0] round;
    } core_ctl_t;

    function automatic logic [31:0] initial_value(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = H0;
            3'd1: v = H1;
            3'd2: v = H2;
            3'd3: v = H3;
            default: v = H4;
        endcase
        return v;
    endfunction
endpackage

[hdl/sha_core.sv]
// SHA-1 round engine: 16-word schedule window, working registers, chaining value.
module sha_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha_pkg::core_ctl_t    ctl,
    input  logic [31:0]           load_word,
    input  logic [2:0]            out_sel,
    output logic [31:0]           out_word
);
    import sha_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] h_reg [5];
    logic [31:0] w_cur, w_new, f_val, k_val, t_val;

    // Next schedule word from the sliding window.
    assign w_new = {w_reg[13][30:0] ^ w_reg[8][30:0] ^ w_reg[2][30:0] ^ w_reg[0][30:0],
                    w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31]};
    assign w_cur = (ctl.round < 7'd16) ? w_reg[0] : w_new;

    // Round function and constant.
    always_comb begin
        if (ctl.round < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end else if (ctl.round < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end else if (ctl.round < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end
    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    // Schedule window: shift in loaded words, then rotate during rounds.
    always_ff @(posedge aclk) begin
        if (ctl.load_en || ctl.round_en) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= ctl.load_en ? load_word : w_cur;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (ctl.round_en) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Chaining value.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.init) begin
            for (int i = 0; i < 5; i++) begin
                h_reg[i] <= initial_value(3'(i));
            end
        end else if (ctl.fold) begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    assign out_word = h_reg[out_sel];
endmodule

[hdl/sha1_message_digest.sv]
// Top level of the SHA-1 digest block.
// Hashes a byte stream with SHA-1 and returns the 160-bit digest as five 32-bit items.
// An accepted item that neither completes a 64-byte block nor is last leaves s_ready high,
// so bytes can follow back to back. A 64th byte drops s_ready for a compression:
// loading the schedule from the 16-word block memory (one read port, registered read),
// 80 rounds and a fold. A last item then drops s_ready for padding writes, length writes
// and one compression, or two compressions when fewer than 9 bytes of the block are free,
// and finally presents five digest items on the m_ side, each held until m_ready; s_ready
// returns after the fifth.
module sha1_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha_pkg::*;

    logic [31:0] mem [16];
    logic [31:0] rd_data_reg;
    logic        mem_we;
    logic [3:0]  mem_waddr, mem_raddr;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_be;

    state_t      state_reg, state_next;
    logic [60:0] count_reg, count_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        pend_last_reg, pend_last_next;
    logic        two_reg, two_next;
    logic [2:0]  idx_reg, idx_next;
    core_ctl_t   ctl;
    logic [31:0] core_word;
    logic [63:0] bit_len;
    logic [5:0]  fill;
    logic        acc;

    assign acc     = s_valid && s_ready;
    assign fill    = count_reg[5:0];
    assign bit_len = {count_reg, 3'b000};

    // Block memory with byte enables and a registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            for (int b = 0; b < 4; b++) begin
                if (mem_be[b]) begin
                    mem[mem_waddr][8*b +: 8] <= mem_wdata[8*b +: 8];
                end
            end
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cnt_reg       <= '0;
            pend_last_reg <= 1'b0;
            two_reg       <= 1'b0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            pend_last_reg <= pend_last_next;
            two_reg       <= two_next;
            idx_reg       <= idx_next;
        end
    end

    // Next state and counters.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        pend_last_next = pend_last_reg;
        two_next       = two_reg;
        idx_next       = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (s_byte_valid) begin
                        count_next = count_reg + 61'd1;
                        if (fill == 6'd63) begin
                            pend_last_next = s_last;
                            state_next     = ST_LOAD;
                            cnt_next       = '0;
                        end else if (s_last) begin
                            state_next = ST_PAD;
                            cnt_next   = '0;
                        end
                    end else if (s_last) begin
                        state_next = ST_PAD;
                        cnt_next   = '0;
                    end
                end
            end
            ST_LOAD: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd16) begin
                    state_next = ST_ROUND;
                    cnt_next   = '0;
                end
            end
            ST_ROUND: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd79) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                cnt_next = '0;
                if (pend_last_reg) begin
                    pend_last_next = 1'b0;
                    state_next     = ST_PAD;
                end else if (two_reg) begin
                    two_next   = 1'b0;
                    state_next = ST_LEN;
                end else if (idx_reg == IDX_DIGEST) begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                // Pad words from the fill position to the end of the block.
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg[3:0] == 4'd15) begin
                    cnt_next = '0;
                    if (fill >= 6'd56) begin
                        two_next   = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                // Length words, or zero words and length after an extra block.
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg[3:0] == 4'd15) begin
                    cnt_next   = '0;
                    idx_next   = IDX_DIGEST;
                    state_next = ST_LOAD;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_INDEX) begin
                        idx_next   = '0;
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        logic [3:0] w;
        logic [5:0] pos;
        w         = cnt_reg[3:0];
        pos       = fill;
        mem_we    = 1'b0;
        mem_waddr = w;
        mem_wdata = '0;
        mem_be    = 4'b1111;
        mem_raddr = cnt_reg[3:0];
        ctl       = '0;
        ctl.round = cnt_reg;
        s_ready   = (state_reg == ST_IDLE);
        m_valid   = (state_reg == ST_OUT);
        unique case (state_reg)
            ST_IDLE: begin
                if (acc && s_byte_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = fill[5:2];
                    mem_wdata = {4{s_data_byte}};
                    unique case (fill[1:0])
                        2'd0: mem_be = 4'b1000;
                        2'd1: mem_be = 4'b0100;
                        2'd2: mem_be = 4'b0010;
                        default: mem_be = 4'b0001;
                    endcase
                end
            end
            ST_LOAD: begin
                ctl.load_en = (cnt_reg != 7'd0);
                ctl.start   = (cnt_reg == 7'd16);
            end
            ST_ROUND: ctl.round_en = 1'b1;
            ST_FINAL: ctl.fold = 1'b1;
            ST_PAD: begin
                if (w > pos[5:2]) begin
                    mem_we = 1'b1;
                end else if (w == pos[5:2]) begin
                    mem_we = 1'b1;
                    unique case (pos[1:0])
                        2'd0: begin mem_wdata = {PAD_BYTE, 24'd0}; mem_be = 4'b1111; end
                        2'd1: begin mem_wdata = {8'd0, PAD_BYTE, 16'd0}; mem_be = 4'b0111; end
                        2'd2: begin mem_wdata = {16'd0, PAD_BYTE, 8'd0}; mem_be = 4'b0011; end
                        default: begin mem_wdata = {24'd0, PAD_BYTE}; mem_be = 4'b0001; end
                    endcase
                end
            end
            ST_LEN: begin
                if (two_reg || fill >= 6'd56 || w >= 4'd14) begin
                    // After an extra block every word is rewritten; otherwise only the length.
                    if (w == 4'd14) begin
                        mem_we = 1'b1; mem_wdata = bit_len[63:32];
                    end else if (w == 4'd15) begin
                        mem_we = 1'b1; mem_wdata = bit_len[31:0];
                    end else if (fill >= 6'd56) begin
                        mem_we = 1'b1;
                    end
                end
            end
            ST_OUT: ;
            default: ;
        endcase
        ctl.init = (state_reg == ST_OUT) && m_ready && (idx_reg == LAST_INDEX);
    end

    sha_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .load_word (rd_data_reg),
        .out_sel   (idx_reg),
        .out_word  (core_word)
    );

    assign m_digest_word = core_word;
    assign m_word_index  = idx_reg;
    assign m_last_word   = (idx_reg == LAST_INDEX);
endmodule

[hdl/sha_checker.sv]
// Port-level checker of the SHA-1 digest block and its bind.
`include "sha1_message_digest_assert.svh"
module sha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word,
    input logic [2:0]  m_word_index,
    input logic        m_last_word
);
    import sha_pkg::*;

    logic out_stall;
    logic idx_last;

    // A digest item that waits, and the last flag its index calls for.
    assign out_stall = m_valid && !m_ready;
    assign idx_last  = (m_word_index == LAST_INDEX);

    `SHA_ASSERT_IMPL(a_idx_range, aclk, aresetn, m_valid, m_word_index <= LAST_INDEX, "bad index")
    `SHA_ASSERT_IMPL(a_last_flag, aclk, aresetn, m_valid, m_last_word == idx_last, "last flag")
    `SHA_ASSERT_NEXT(a_hold, aclk, aresetn, out_stall, m_valid && $stable(m_digest_word), "not held")
    `SHA_ASSERT_IMPL(a_in_closed, aclk, aresetn, m_valid, !s_ready, "input open")
endmodule

bind sha1_message_digest sha_checker u_sha_checker (.*);
